>>> rtl/core/masked_u8_squared_difference_sum_defines.svh
// Assertion macros for the masked squared-difference sum merge module
`ifndef MASKED_U8_SQUARED_DIFFERENCE_SUM_DEFINES_SVH
`define MASKED_U8_SQUARED_DIFFERENCE_SUM_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define MSDS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msds assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset
`define MSDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msds assertion failed");

`endif

>>> rtl/core/msds_pkg.sv
// Shared constants and types for the masked squared-difference sum block
package msds_pkg;

   localparam int LANES      = 8;
   localparam int PIX_W      = 64;
   localparam int BYTES      = PIX_W / 8;
   localparam int COUNT_W    = 4;
   localparam int SQ_W       = 16;
   localparam int LANE_SUM_W = SQ_W + $clog2(LANES + 1);
   localparam int TOTAL_W    = 64;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_MASK_ENABLE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MATCH_VALUE = CSR_IDX_W'(1);

   typedef logic [LANES-1:0][SQ_W-1:0] sq_vec_type;

   typedef struct packed {
      logic valid;
      logic frame_end;
   } stage_ctrl_type;

endpackage

>>> rtl/core/msds_lane.sv
// One lane: absolute pixel difference, square and mask gate, registered
module msds_lane (
   input  logic                      clock,
   input  logic                      load,
   input  logic [7:0]                pixel_a,
   input  logic [7:0]                pixel_b,
   input  logic [7:0]                mask_byte,
   input  logic                      lane_on,
   input  logic                      mask_enable,
   input  logic [7:0]                mask_match_value,
   output logic [msds_pkg::SQ_W-1:0] sq_ff
);

   logic [7:0]                diff;
   logic                      admitted;
   logic [msds_pkg::SQ_W-1:0] sq_in;

   always_comb begin
      diff     = (pixel_a >= pixel_b) ? (pixel_a - pixel_b) : (pixel_b - pixel_a);
      admitted = lane_on && (!mask_enable || (mask_byte == mask_match_value));
      sq_in    = admitted ? (msds_pkg::SQ_W'(diff) * msds_pkg::SQ_W'(diff))
                          : '0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sq_ff <= sq_in;
      end
   end

endmodule

>>> rtl/core/msds_merge.sv
// Lane adder tree, frame accumulator and result register
`include "masked_u8_squared_difference_sum_defines.svh"

module msds_merge (
   input  logic                         clock,
   input  logic                         reset,
   input  msds_pkg::stage_ctrl_type     s1_ctrl,
   input  msds_pkg::sq_vec_type         s1_sq,
   output logic                         s2_load,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [msds_pkg::TOTAL_W-1:0] rsp_frame_sum
);

   logic [msds_pkg::LANE_SUM_W-1:0] lane_sum;
   logic [msds_pkg::LANE_SUM_W-1:0] sum_ff;
   msds_pkg::stage_ctrl_type        s2_ctrl_ff;
   msds_pkg::stage_ctrl_type        s2_ctrl_in;
   logic [msds_pkg::TOTAL_W-1:0]    total_ff;
   logic [msds_pkg::TOTAL_W-1:0]    total_in;
   logic [msds_pkg::TOTAL_W-1:0]    frame_total;
   logic [msds_pkg::TOTAL_W-1:0]    rsp_sum_ff;
   logic [msds_pkg::TOTAL_W-1:0]    rsp_sum_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic                            rsp_free;
   logic                            acc_take;
   logic                            take_end;

   always_comb begin
      lane_sum = '0;
      for (int i = 0; i < msds_pkg::LANES; i++) begin
         lane_sum = lane_sum + msds_pkg::LANE_SUM_W'(s1_sq[i]);
      end
   end

   // A frame-end transfer needs the result slot; other items never wait on it
   always_comb begin
      rsp_free    = !rsp_valid_ff || !rsp_stall;
      acc_take    = s2_ctrl_ff.valid && (!s2_ctrl_ff.frame_end || rsp_free);
      take_end    = acc_take && s2_ctrl_ff.frame_end;
      s2_load     = !s2_ctrl_ff.valid || acc_take;
      s2_ctrl_in  = s2_load ? s1_ctrl : s2_ctrl_ff;
      frame_total = total_ff + msds_pkg::TOTAL_W'(sum_ff);

      total_in = total_ff;
      if (acc_take) begin
         total_in = s2_ctrl_ff.frame_end ? '0 : frame_total;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sum_in   = rsp_sum_ff;
      if (take_end) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = frame_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctrl_ff   <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_ctrl_ff   <= s2_ctrl_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         sum_ff <= lane_sum;
      end
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_frame_sum = rsp_sum_ff;

   `MSDS_ASSERT_NEXT(a_clear_after_end, clock, reset, take_end, total_ff == '0)
   `MSDS_ASSERT_NEXT(a_result_after_end, clock, reset, take_end, rsp_valid_ff)
   `MSDS_ASSERT_NOW(a_no_overwrite, clock, reset, take_end, !(rsp_valid_ff && rsp_stall))
   `MSDS_ASSERT_NEXT(a_rsp_only_from_end, clock, reset,
      !rsp_valid_ff && !take_end, !rsp_valid_ff)

endmodule

>>> rtl/core/masked_u8_squared_difference_sum.sv
// Masked sum of squared 8-bit pixel differences over a frame, eight lanes per item
// A frame-end item is registered in the lanes, then in stage two, then on rsp.
// Throughput: one item per cycle unless a frame-end item waits on a stalled result;
// lane squares, one adder tree and the 64-bit accumulator each take a stage.
// Reset: synchronous, active high; clears the running total, the pipeline valid
// bits, the pending result and both configuration registers.
module masked_u8_squared_difference_sum (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [msds_pkg::PIX_W-1:0]      req_pixels_first,
   input  logic [msds_pkg::PIX_W-1:0]      req_pixels_second,
   input  logic [msds_pkg::PIX_W-1:0]      req_mask_bytes,
   input  logic [msds_pkg::COUNT_W-1:0]    req_lane_count,
   input  logic                            req_frame_end,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [msds_pkg::TOTAL_W-1:0]    rsp_frame_sum,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [msds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [msds_pkg::CSR_DATA_W-1:0] csr_data
);

   logic                       mask_enable_ff;
   logic                       mask_enable_in;
   logic [7:0]                 match_value_ff;
   logic [7:0]                 match_value_in;
   msds_pkg::stage_ctrl_type   s1_ctrl_ff;
   msds_pkg::stage_ctrl_type   s1_ctrl_in;
   msds_pkg::sq_vec_type       s1_sq;
   logic                       s1_load;
   logic                       s2_load;
   logic [msds_pkg::LANES-1:0] lane_on;

   assign csr_ready = 1'b1;

   always_comb begin
      mask_enable_in = mask_enable_ff;
      match_value_in = match_value_ff;
      if (csr_valid) begin
         case (csr_index)
            msds_pkg::REG_MASK_ENABLE: mask_enable_in = csr_data[0];
            msds_pkg::REG_MATCH_VALUE: match_value_in = csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Advance stage one when it is empty or its item moves on
   always_comb begin
      s1_load              = !s1_ctrl_ff.valid || s2_load;
      s1_ctrl_in           = s1_ctrl_ff;
      if (s1_load) begin
         s1_ctrl_in.valid     = req_valid;
         s1_ctrl_in.frame_end = req_frame_end;
      end
   end

   assign req_stall = !s1_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_enable_ff <= 1'b0;
         match_value_ff <= '0;
         s1_ctrl_ff     <= '0;
      end else begin
         mask_enable_ff <= mask_enable_in;
         match_value_ff <= match_value_in;
         s1_ctrl_ff     <= s1_ctrl_in;
      end
   end

   for (genvar i = 0; i < msds_pkg::LANES; i++) begin : g_lane
      logic [7:0] pix_a;
      logic [7:0] pix_b;
      logic [7:0] mask_b;

      // Lanes past the input words see zero pixels and add nothing
      if (i < msds_pkg::BYTES) begin : g_byte
         assign pix_a  = req_pixels_first[8*i +: 8];
         assign pix_b  = req_pixels_second[8*i +: 8];
         assign mask_b = req_mask_bytes[8*i +: 8];
      end else begin : g_zero
         assign pix_a  = 8'd0;
         assign pix_b  = 8'd0;
         assign mask_b = 8'd0;
      end

      // A count above the lane total admits every lane
      assign lane_on[i] = (32'(req_lane_count) > i);

      msds_lane u_lane (
         .clock            (clock),
         .load             (s1_load),
         .pixel_a          (pix_a),
         .pixel_b          (pix_b),
         .mask_byte        (mask_b),
         .lane_on          (lane_on[i]),
         .mask_enable      (mask_enable_ff),
         .mask_match_value (match_value_ff),
         .sq_ff            (s1_sq[i])
      );
   end

   msds_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .s1_ctrl       (s1_ctrl_ff),
      .s1_sq         (s1_sq),
      .s2_load       (s2_load),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_frame_sum (rsp_frame_sum)
   );

endmodule
